// ----- src/pv4tc_pkg.sv -----
// ----------------------------------------------------------------------------
// pv4tc_pkg
// Shared types and constants for the private IPv4 text checker.
// ----------------------------------------------------------------------------
package pv4tc_pkg;

  // character codes
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;

  // part bookkeeping
  localparam logic [1:0]  MAX_DIGITS = 2'd3;
  localparam logic [1:0]  LAST_PART  = 2'd3;
  localparam logic [11:0] OCTET_MAX  = 12'd255;

  // private range constants
  localparam logic [7:0] NET_TEN       = 8'd10;
  localparam logic [7:0] NET_172       = 8'd172;
  localparam logic [7:0] NET_172_LOW   = 8'd16;
  localparam logic [7:0] NET_172_HIGH  = 8'd31;
  localparam logic [7:0] NET_192       = 8'd192;
  localparam logic [7:0] NET_192_SUB   = 8'd168;

  // one input item
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_marker;
  } item_t;

  // one result item
  typedef struct packed {
    logic is_private;
    logic well_formed;
  } result_t;

endpackage

// ----- src/pv4tc_in_reg.sv -----
// ----------------------------------------------------------------------------
// pv4tc_in_reg
// Input register: holds one accepted transfer until the parser consumes it.
// ----------------------------------------------------------------------------
module pv4tc_in_reg (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  pv4tc_pkg::item_t in_item,
  output logic            item_valid,
  output pv4tc_pkg::item_t item,
  input  logic            item_take
);
  import pv4tc_pkg::*;

  // free when empty or emptied this cycle
  assign in_ready = !item_valid || item_take;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

// ----- src/pv4tc_parser.sv -----
// ----------------------------------------------------------------------------
// pv4tc_parser
// Per-character parse state and end-of-text verdict, one item per cycle; an end marker waits for a free result slot.
// ----------------------------------------------------------------------------
module pv4tc_parser (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  pv4tc_pkg::item_t   item,
  output logic               item_take,
  input  logic               res_ready,
  output logic               res_valid,
  output pv4tc_pkg::result_t res
);
  import pv4tc_pkg::*;

  logic [1:0] part_index, part_index_next;
  logic [7:0] part_value, part_value_next;
  logic [1:0] digit_count, digit_count_next;
  logic       leading_zero, leading_zero_next;
  logic       failed, failed_next;
  logic [7:0] first_octet, first_octet_next;
  logic [7:0] second_octet, second_octet_next;

  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [11:0] value_ten;
  logic        ok;
  logic        priv;

  // characters always go through, the end marker waits for the result slot
  assign item_take = item_valid && (!item.end_marker || res_ready);
  assign res_valid = item_valid && item.end_marker && res_ready;

  // character classes
  assign is_digit = (item.char_code >= CHAR_ZERO) && (item.char_code <= CHAR_NINE);
  assign is_dot   = (item.char_code == CHAR_DOT);
  assign digit    = 4'(item.char_code - CHAR_ZERO);

  // part value times ten plus digit, by shift and add
  assign value_ten = {1'b0, part_value, 3'b000} + {3'b000, part_value, 1'b0}
                   + {8'h00, digit};

  // verdict on the end marker
  always_comb begin
    ok = !failed && (part_index == LAST_PART) && (digit_count != 2'd0);
    priv = 1'b0;
    if (ok) begin
      if (first_octet == NET_TEN) begin
        priv = 1'b1;
      end else if (first_octet == NET_172 && second_octet >= NET_172_LOW &&
                   second_octet <= NET_172_HIGH) begin
        priv = 1'b1;
      end else if (first_octet == NET_192 && second_octet == NET_192_SUB) begin
        priv = 1'b1;
      end
    end
    res.well_formed = ok;
    res.is_private  = priv;
  end

  // next state for one character or the end marker
  always_comb begin
    part_index_next   = part_index;
    part_value_next   = part_value;
    digit_count_next  = digit_count;
    leading_zero_next = leading_zero;
    failed_next       = failed;
    first_octet_next  = first_octet;
    second_octet_next = second_octet;
    if (item.end_marker) begin
      part_index_next   = 2'd0;
      part_value_next   = 8'd0;
      digit_count_next  = 2'd0;
      leading_zero_next = 1'b0;
      failed_next       = 1'b0;
      first_octet_next  = 8'd0;
      second_octet_next = 8'd0;
    end else if (!failed) begin
      if (is_digit) begin
        if (digit_count >= MAX_DIGITS || leading_zero || value_ten > OCTET_MAX) begin
          failed_next = 1'b1;
        end else begin
          if (digit_count == 2'd0 && digit == 4'd0) begin
            leading_zero_next = 1'b1;
          end
          part_value_next  = value_ten[7:0];
          digit_count_next = digit_count + 2'd1;
        end
      end else if (is_dot) begin
        if (digit_count == 2'd0 || part_index >= LAST_PART) begin
          failed_next = 1'b1;
        end else begin
          if (part_index == 2'd0) begin
            first_octet_next = part_value;
          end else if (part_index == 2'd1) begin
            second_octet_next = part_value;
          end
          part_index_next   = part_index + 2'd1;
          part_value_next   = 8'd0;
          digit_count_next  = 2'd0;
          leading_zero_next = 1'b0;
        end
      end else begin
        failed_next = 1'b1;
      end
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      part_index   <= 2'd0;
      part_value   <= 8'd0;
      digit_count  <= 2'd0;
      leading_zero <= 1'b0;
      failed       <= 1'b0;
      first_octet  <= 8'd0;
      second_octet <= 8'd0;
    end else if (item_take) begin
      part_index   <= part_index_next;
      part_value   <= part_value_next;
      digit_count  <= digit_count_next;
      leading_zero <= leading_zero_next;
      failed       <= failed_next;
      first_octet  <= first_octet_next;
      second_octet <= second_octet_next;
    end
  end

endmodule

// ----- src/pv4tc_out_reg.sv -----
// ----------------------------------------------------------------------------
// pv4tc_out_reg
// Result register: holds one verdict until the receiver takes the transfer.
// ----------------------------------------------------------------------------
module pv4tc_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  pv4tc_pkg::result_t res,
  output logic               out_valid,
  input  logic               out_ready,
  output pv4tc_pkg::result_t out_res
);
  import pv4tc_pkg::*;

  // free when empty or drained this cycle
  assign res_ready = !out_valid || out_ready;

  // occupancy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ----- src/private_ipv4_text_checker_top.sv -----
// ----------------------------------------------------------------------------
// private_ipv4_text_checker_top
// Checks dotted-decimal IPv4 text and flags RFC 1918 private addresses.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one character per transfer in tdata; tuser set marks the
//   end of the text and its tdata is ignored. m_axis carries one verdict per
//   end marker: tdata[0] well formed, tdata[1] private (0 if not well formed).
//   Throughput: one input transfer per cycle, sustained unless an end
//   marker meets a full result register. Characters are consumed from
//   the input register in the cycle after acceptance; the parse state is
//   a handful of flip-flops updated by a multiply-by-ten shift-add and a
//   compare against 255. After the end marker is accepted, the verdict
//   reaches m_axis through the input register, then the result register.
//   When the receiver stalls, the verdict waits in the result register and
//   characters keep flowing; an end marker that meets a full result
//   register waits in the input register, which then holds off s_axis.
//   Reset (rst, synchronous) empties both registers and clears the parse
//   state, so the next character starts a new address.
// ----------------------------------------------------------------------------
module private_ipv4_text_checker_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] char_code
  input  logic       s_axis_tuser,  // [0] end_marker
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [0] well_formed, [1] is_private, rest zero
);
  import pv4tc_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    item_take;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  result_t out_res;

  // pack the input transfer
  assign in_item.char_code  = s_axis_tdata;
  assign in_item.end_marker = s_axis_tuser;

  // input register
  pv4tc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  // parse state and verdict
  pv4tc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_ready  (res_ready),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register
  pv4tc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  // unpack the output transfer
  assign m_axis_tdata = {6'b000000, out_res.is_private, out_res.well_formed};

endmodule
